// ----- hw/rtl/wss_pkg.sv -----
package wss_pkg;

  localparam int unsigned NeedleMax = 32;
  localparam int unsigned LenW      = $clog2(NeedleMax + 1);
  localparam int unsigned IdxW      = (NeedleMax > 1) ? $clog2(NeedleMax) : 1;
  localparam int unsigned CharW     = 16;
  localparam int unsigned AddrW     = 32;

  localparam logic [1:0] OpStart  = 2'd0;
  localparam logic [1:0] OpNeedle = 2'd1;
  localparam logic [1:0] OpHay    = 2'd2;

  typedef struct packed {
    logic             clear;
    logic             scan;
    logic [CharW-1:0] ch;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/wss_in_if.sv -----
interface wss_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [wss_pkg::CharW-1:0] char_word;
  logic [wss_pkg::AddrW-1:0] base_address;

  modport source (output valid, output opcode, output char_word, output base_address,
                  input ready);
  modport sink   (input valid, input opcode, input char_word, input base_address,
                  output ready);
endinterface

// ----- hw/rtl/wss_out_if.sv -----
interface wss_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [wss_pkg::AddrW-1:0] match_address;
  logic                      needle_too_long;

  modport source (output valid, output found, output match_address,
                  output needle_too_long, input ready);
  modport sink   (input valid, input found, input match_address,
                  input needle_too_long, output ready);
endinterface

// ----- hw/rtl/wss_cell.sv -----
module wss_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wss_pkg::cell_ctl_t        ctl_i,
  input  logic                      wr_en_i,
  input  logic [wss_pkg::CharW-1:0] wr_char_i,
  input  logic                      prev_i,
  output logic                      hit_o,
  output logic                      match_o
);

  logic [wss_pkg::CharW-1:0] char_q;
  logic                      pm_q;
  logic                      pm_d;

  assign hit_o   = prev_i && (char_q == ctl_i.ch);
  assign match_o = pm_q;

  always_comb begin
    pm_d = pm_q;
    if (ctl_i.clear) begin
      pm_d = 1'b0;
    end else if (ctl_i.scan) begin
      pm_d = hit_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      char_q <= wr_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= 1'b0;
    end else begin
      pm_q <= pm_d;
    end
  end

endmodule

// ----- hw/rtl/wide_substring_search_unit.sv -----
// Streaming first-occurrence search of a zero-terminated 16-bit needle in a
// zero-terminated 16-bit haystack. A start transfer gives the haystack base,
// needle transfers load one cell each of a row of 32 cells, and haystack
// transfers are taken one per clock, a terminator only with the output free:
// every cell compares the word against its stored character and passes its
// partial-match bit to the next cell, and one 32-bit subtract gives the match
// address. The haystack terminator produces the single result, registered in
// the next cycle; other input transfers are taken even while a result waits.
module wide_substring_search_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  wss_in_if.sink    query_i,
  wss_out_if.source result_o
);

  localparam int unsigned N = wss_pkg::NeedleMax;

  logic [wss_pkg::LenW-1:0]  len_q, len_d;
  logic                      ovf_q, ovf_d;
  logic                      closed_q, closed_d;
  logic                      done_q, done_d;
  logic [wss_pkg::AddrW-1:0] base_q, base_d;
  logic [wss_pkg::AddrW-1:0] haddr_q, haddr_d;
  logic                      seen_q, seen_d;
  logic [wss_pkg::AddrW-1:0] first_q, first_d;

  logic                      out_valid_q, out_valid_d;
  logic                      found_q, found_d;
  logic [wss_pkg::AddrW-1:0] addr_q, addr_d;
  logic                      tl_q, tl_d;

  wss_pkg::cell_ctl_t ctl;
  logic [N-1:0]       wr_en;
  logic [N-1:0]       hit;
  logic [N-1:0]       pm;
  logic [N-1:0]       prev;

  logic                      xfer;
  logic                      emit;
  logic                      out_free;
  logic                      is_hay;
  logic                      scanning;
  logic [wss_pkg::LenW-1:0]  lm1;
  logic [wss_pkg::IdxW-1:0]  last_idx;
  logic [wss_pkg::AddrW-1:0] back_off;
  logic                      do_write;
  logic                      res_found;

  assign out_free = !out_valid_q || result_o.ready;
  assign is_hay   = (query_i.opcode == wss_pkg::OpHay) && !done_q;
  assign emit     = is_hay && (query_i.char_word == '0);
  assign query_i.ready = out_free || !emit;
  assign xfer     = query_i.valid && query_i.ready;

  assign scanning = (len_q != '0) && !ovf_q;
  assign lm1      = len_q - wss_pkg::LenW'(1);
  assign last_idx = lm1[wss_pkg::IdxW-1:0];
  assign back_off = {{(wss_pkg::AddrW - wss_pkg::LenW - 1){1'b0}}, lm1, 1'b0};

  assign do_write = xfer && (query_i.opcode == wss_pkg::OpNeedle) && !done_q && !closed_q
                    && (query_i.char_word != '0)
                    && (len_q < wss_pkg::LenW'(N));

  assign ctl.clear = xfer && (query_i.opcode == wss_pkg::OpStart);
  assign ctl.scan  = xfer && is_hay && !emit && scanning;
  assign ctl.ch    = query_i.char_word;

  // cell 0 always has a matched prefix of length zero in front of it
  assign prev = {pm[N-2:0], 1'b1};

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign wr_en[g] = do_write && (len_q[wss_pkg::IdxW-1:0] == wss_pkg::IdxW'(g));
    wss_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .wr_en_i   (wr_en[g]),
      .wr_char_i (query_i.char_word),
      .prev_i    (prev[g]),
      .hit_o     (hit[g]),
      .match_o   (pm[g])
    );
  end

  assign res_found = !ovf_q && (base_q != '0) && ((len_q == '0) || seen_q);

  always_comb begin
    len_d    = len_q;
    ovf_d    = ovf_q;
    closed_d = closed_q;
    done_d   = done_q;
    base_d   = base_q;
    haddr_d  = haddr_q;
    seen_d   = seen_q;
    first_d  = first_q;
    if (xfer) begin
      case (query_i.opcode)
        wss_pkg::OpStart: begin
          len_d    = '0;
          ovf_d    = 1'b0;
          closed_d = 1'b0;
          done_d   = 1'b0;
          base_d   = query_i.base_address;
          haddr_d  = query_i.base_address;
          seen_d   = 1'b0;
          first_d  = '0;
        end
        wss_pkg::OpNeedle: begin
          if (!done_q && !closed_q) begin
            if (query_i.char_word == '0) begin
              closed_d = 1'b1;
            end else if (len_q < wss_pkg::LenW'(N)) begin
              len_d = len_q + wss_pkg::LenW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        wss_pkg::OpHay: begin
          if (!done_q) begin
            closed_d = 1'b1;
            if (emit) begin
              done_d = 1'b1;
            end else begin
              haddr_d = haddr_q + wss_pkg::AddrW'(2);
              if (scanning && hit[last_idx] && !seen_q) begin
                seen_d  = 1'b1;
                first_d = haddr_q - back_off;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    addr_d      = addr_q;
    tl_d        = tl_q;
    if (xfer && emit) begin
      out_valid_d = 1'b1;
      found_d     = res_found;
      addr_d      = res_found ? ((len_q == '0) ? base_q : first_q) : '0;
      tl_d        = ovf_q;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      closed_q    <= 1'b0;
      done_q      <= 1'b0;
      base_q      <= '0;
      haddr_q     <= '0;
      seen_q      <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      closed_q    <= closed_d;
      done_q      <= done_d;
      base_q      <= base_d;
      haddr_q     <= haddr_d;
      seen_q      <= seen_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    addr_q  <= addr_d;
    tl_q    <= tl_d;
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.found           = found_q;
  assign result_o.match_address   = addr_q;
  assign result_o.needle_too_long = tl_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= wss_pkg::LenW'(N))
    else $error("needle length beyond capacity");

  a_seen_needs_needle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (len_q != '0) && !ovf_q)
    else $error("match recorded without a stored needle");

  a_result_closes_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && emit) |=> out_valid_q && done_q)
    else $error("terminator did not produce a result");

  a_found_not_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && found_q) |-> !tl_q)
    else $error("found reported together with overflow");

endmodule

// ----- test/tb_wide_substring_search_unit.sv -----
`timescale 1ns / 1ps

module tb_wide_substring_search_unit;

  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LiveTarget = 560;

  typedef struct packed {
    logic                      found;
    logic [wss_pkg::AddrW-1:0] match_address;
    logic                      needle_too_long;
  } search_result_t;

  typedef struct packed {
    logic [1:0]                op;
    logic [wss_pkg::CharW-1:0] ch;
    logic [wss_pkg::AddrW-1:0] base;
    logic [5:0]                reps;
    logic                      typed;
    search_result_t            want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wss_in_if  query_if ();
  wss_out_if result_if ();

  wide_substring_search_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .query_i  (query_if),
    .result_o (result_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // search state mirrored from the block
  logic [wss_pkg::CharW-1:0]     needle_cell [wss_pkg::NeedleMax] = '{default: '0};
  int unsigned                   needle_len  = 0;
  logic [wss_pkg::NeedleMax-1:0] chain_bits  = '0;
  logic [wss_pkg::AddrW-1:0]     q_base      = '0;
  logic [wss_pkg::AddrW-1:0]     q_pos       = '0;
  logic [wss_pkg::AddrW-1:0]     hit_addr    = '0;
  logic                          hit_seen    = 1'b0;
  logic                          too_long    = 1'b0;
  logic                          needle_shut = 1'b0;
  logic                          query_over  = 1'b0;

  search_result_t            results_due [$];
  search_result_t            oldest_result;
  int unsigned               mismatches  = 0;
  int unsigned               idle_cycles = 0;
  int unsigned               cycle_count = 0;
  int unsigned               sink_hold   = 0;
  logic [wss_pkg::CharW-1:0] alphabet [3];

  stim_row_t directed_rows [40] = '{
    '{wss_pkg::OpHay,    16'h0000, 32'h0000_0000, 6'd1,  1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{OpUnused,          16'hFFFF, 32'hFFFF_FFFF, 6'd1,  1'b0, '0},
    '{wss_pkg::OpStart,  16'h0000, 32'hFFFF_FFFE, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'hFFFF, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0000, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h1234, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0001, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'hFFFF, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0000, 32'h0000_0000, 6'd1,  1'b1, '{1'b1, 32'h0000_0000, 1'b0}},
    '{wss_pkg::OpHay,    16'h5555, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpStart,  16'h0000, 32'h0000_1000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0000, 32'h0000_0000, 6'd1,  1'b1, '{1'b1, 32'h0000_1000, 1'b0}},
    '{wss_pkg::OpStart,  16'h0000, 32'h0000_2000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0041, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0042, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0041, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0042, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0000, 32'h0000_0000, 6'd1,  1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{wss_pkg::OpStart,  16'h0000, 32'h0000_3000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h8000, 32'h0000_0000, 6'd33, 1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0000, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h8000, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0000, 32'h0000_0000, 6'd1,  1'b1, '{1'b0, 32'h0000_0000, 1'b1}},
    '{wss_pkg::OpStart,  16'h0000, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0041, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0000, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0041, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0000, 32'h0000_0000, 6'd1,  1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{wss_pkg::OpStart,  16'h0000, 32'h8000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0001, 32'h0000_0000, 6'd32, 1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0000, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0001, 32'h0000_0000, 6'd33, 1'b0, '0},
    '{wss_pkg::OpHay,    16'h0000, 32'h0000_0000, 6'd1,  1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
    '{wss_pkg::OpStart,  16'h0000, 32'h0000_4000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0041, 32'h0000_0000, 6'd2,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0042, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpNeedle, 16'h0000, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0041, 32'h0000_0000, 6'd3,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0042, 32'h0000_0000, 6'd1,  1'b0, '0},
    '{wss_pkg::OpHay,    16'h0000, 32'h0000_0000, 6'd1,  1'b0, '0}
  };

  function automatic bit search_step(input logic [1:0] op,
                                     input logic [wss_pkg::CharW-1:0] ch,
                                     input logic [wss_pkg::AddrW-1:0] base,
                                     output search_result_t res);
    res = '0;
    if (op == wss_pkg::OpStart) begin
      chain_bits  = '0;
      needle_len  = 0;
      q_base      = base;
      q_pos       = '0;
      hit_seen    = 1'b0;
      hit_addr    = '0;
      too_long    = 1'b0;
      needle_shut = 1'b0;
      query_over  = 1'b0;
      return 1'b0;
    end
    if (op == OpUnused || query_over) return 1'b0;
    if (op == wss_pkg::OpNeedle) begin
      if (!needle_shut) begin
        if (ch == '0) begin
          needle_shut = 1'b1;
        end else if (needle_len < wss_pkg::NeedleMax) begin
          needle_cell[needle_len] = ch;
          needle_len++;
        end else begin
          too_long = 1'b1;
        end
      end
      return 1'b0;
    end
    needle_shut = 1'b1;
    if (ch != '0) begin
      if (needle_len != 0 && !too_long) begin
        for (int i = wss_pkg::NeedleMax - 1; i > 0; i--)
          if (i < needle_len) chain_bits[i] = chain_bits[i-1] && (needle_cell[i] == ch);
        chain_bits[0] = (needle_cell[0] == ch);
        if (chain_bits[needle_len-1] && !hit_seen) begin
          hit_seen = 1'b1;
          hit_addr = q_base + ((q_pos - wss_pkg::AddrW'(needle_len - 1)) << 1);
        end
      end
      q_pos++;
      return 1'b0;
    end
    query_over = 1'b1;
    res.needle_too_long = too_long;
    if (too_long || q_base == '0) begin
      res.found         = 1'b0;
      res.match_address = '0;
    end else if (needle_len == 0) begin
      res.found         = 1'b1;
      res.match_address = q_base;
    end else begin
      res.found         = hit_seen;
      res.match_address = hit_seen ? hit_addr : '0;
    end
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones, none in the calm windows
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((cycle_count % 640) < 128) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [wss_pkg::CharW-1:0] pick_char();
    if ($urandom_range(0, 9) == 0) return wss_pkg::CharW'($urandom_range(1, 65535));
    return alphabet[$urandom_range(0, 2)];
  endfunction

  task automatic feed_word(input logic [1:0] op, input logic [wss_pkg::CharW-1:0] ch,
                           input logic [wss_pkg::AddrW-1:0] base, input logic typed,
                           input search_result_t want);
    int unsigned    gap;
    search_result_t res;
    gap = idle_gap();
    if (gap != 0) begin
      query_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    query_if.valid        <= 1'b1;
    query_if.opcode       <= op;
    query_if.char_word    <= ch;
    query_if.base_address <= base;
    do @(posedge clk_i); while (!query_if.ready);
    if (search_step(op, ch, base, res)) begin
      results_due.push_back(typed ? want : res);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (sink_hold != 0) begin
      result_if.ready <= 1'b0;
      sink_hold       <= sink_hold - 1;
    end else begin
      result_if.ready <= 1'b1;
      sink_hold       <= idle_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found %0b addr %h too_long %0b", result_if.found,
                   result_if.match_address, result_if.needle_too_long);
      end else begin
        oldest_result = results_due.pop_front();
        if (result_if.found !== oldest_result.found ||
            result_if.match_address !== oldest_result.match_address ||
            result_if.needle_too_long !== oldest_result.needle_too_long) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found %0b addr %h too_long %0b, got %0b %h %0b",
                     oldest_result.found, oldest_result.match_address,
                     oldest_result.needle_too_long, result_if.found,
                     result_if.match_address, result_if.needle_too_long);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((query_if.valid && query_if.ready) || (result_if.valid && result_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [wss_pkg::CharW-1:0] needle_buf [40];
    logic [wss_pkg::CharW-1:0] hay_buf [64];
    logic [wss_pkg::AddrW-1:0] base;
    int unsigned               nlen;
    int unsigned               hlen;
    int unsigned               spot;
    int unsigned               r;
    int unsigned               live_items;
    logic                      counted;

    rst_ni                = 1'b0;
    query_if.valid        = 1'b0;
    query_if.opcode       = wss_pkg::OpStart;
    query_if.char_word    = '0;
    query_if.base_address = '0;
    live_items            = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      repeat (directed_rows[k].reps)
        feed_word(directed_rows[k].op, directed_rows[k].ch, directed_rows[k].base,
                  directed_rows[k].typed, directed_rows[k].want);

    while (live_items < LiveTarget) begin
      foreach (alphabet[a]) alphabet[a] = wss_pkg::CharW'($urandom_range(1, 65535));
      r = $urandom_range(0, 9);
      if (r == 0) base = '0;
      else if (r == 1) base = 32'hFFFF_FF00 | wss_pkg::AddrW'($urandom_range(0, 255));
      else base = $urandom;

      // occasionally leave out the start so the words fall on the previous query, mostly a finished one
      counted = ($urandom_range(0, 19) != 0);
      if (counted) begin
        feed_word(wss_pkg::OpStart, wss_pkg::CharW'($urandom), base, 1'b0, '0);
        live_items++;
      end

      r = $urandom_range(0, 99);
      if (r < 8) nlen = 0;
      else if (r < 80) nlen = $urandom_range(1, 5);
      else if (r < 90) nlen = $urandom_range(6, 31);
      else if (r < 95) nlen = wss_pkg::NeedleMax;
      else nlen = $urandom_range(wss_pkg::NeedleMax + 1, wss_pkg::NeedleMax + 4);
      for (int i = 0; i < nlen; i++) needle_buf[i] = pick_char();

      hlen = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 60);
      for (int i = 0; i < hlen; i++) hay_buf[i] = pick_char();
      if (nlen != 0 && nlen <= hlen && $urandom_range(0, 1) == 1) begin
        spot = $urandom_range(0, hlen - nlen);
        for (int i = 0; i < nlen; i++) hay_buf[spot + i] = needle_buf[i];
      end

      for (int i = 0; i < nlen; i++) begin
        feed_word(wss_pkg::OpNeedle, needle_buf[i], $urandom, 1'b0, '0);
        live_items += counted;
      end
      if ($urandom_range(0, 9) != 0) begin
        feed_word(wss_pkg::OpNeedle, '0, $urandom, 1'b0, '0);
        live_items += counted;
        if ($urandom_range(0, 9) == 0)
          feed_word(wss_pkg::OpNeedle, pick_char(), $urandom, 1'b0, '0);
      end

      for (int i = 0; i < hlen; i++) begin
        if ($urandom_range(0, 29) == 0)
          feed_word(OpUnused, wss_pkg::CharW'($urandom), $urandom, 1'b0, '0);
        feed_word(wss_pkg::OpHay, hay_buf[i], $urandom, 1'b0, '0);
        live_items += counted;
      end
      if ($urandom_range(0, 19) != 0) begin
        feed_word(wss_pkg::OpHay, '0, $urandom, 1'b0, '0);
        live_items += counted;
        if ($urandom_range(0, 9) == 0)
          feed_word(wss_pkg::OpHay, pick_char(), $urandom, 1'b0, '0);
      end
    end
    query_if.valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
